// File: sv/owrs_pkg.sv
// Shared types, codes and widths for the 1-Wire ROM search core.
package owrs_pkg;

	// Field widths fixed by the interface
	localparam int unsigned OP_W       = 2;
	localparam int unsigned CMD_W      = 8;
	localparam int unsigned ROM_CODE_W = 64;
	localparam int unsigned STATUS_W   = 2;
	localparam int unsigned COUNT_W    = 8;
	// Bit position 1..ROM_BITS, ROM_BITS+1 after start or pass end; discrepancy 0..ROM_BITS
	localparam int unsigned POS_W      = 7;

	localparam int unsigned    ROM_BITS_DEFAULT = 64;
	localparam logic [CMD_W-1:0]   CMD_RESET    = 8'hF0;
	localparam logic [COUNT_W-1:0] COUNT_MAX    = 8'hFF;

	typedef enum logic [OP_W-1:0] {
		OP_START = 2'd0,
		OP_PASS  = 2'd1,
		OP_BIT   = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK          = 2'd0,
		STATUS_NO_PRESENCE = 2'd1,
		STATUS_NO_ANSWER   = 2'd2
	} status_t;

	// One input transaction
	typedef struct packed {
		logic [OP_W-1:0] operation;
		logic            presence;
		logic            true_bit;
		logic            complement_bit;
	} item_t;

	// One result transaction
	typedef struct packed {
		logic                  write_bit;
		logic [CMD_W-1:0]      command_byte;
		logic [ROM_CODE_W-1:0] found_rom;
		logic                  rom_valid;
		logic                  search_done;
		logic [STATUS_W-1:0]   status;
		logic [COUNT_W-1:0]    device_count;
	} result_t;

endpackage

// File: sv/owrs_in_stage.sv
// Input register stage: captures one transaction and holds it until the decision stage takes it.
module owrs_in_stage
	import owrs_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_ready,
	input  item_t item_in,
	input  logic  take,
	output logic  valid_s1,
	output item_t item_s1
);

	// Accept when empty or when the held transaction moves on this cycle
	assign item_ready = !valid_s1 || take;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	// Capture payload
	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item_in;
		end
	end

endmodule

// File: sv/owrs_decide.sv
// Search decision logic: ROM store, discrepancy tracking, pass control and the command register.
module owrs_decide
	import owrs_pkg::*;
#(
	parameter int unsigned ROM_BITS = ROM_BITS_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CMD_W-1:0] cfg_wdata,
	input  logic             take,
	input  item_t            item_s1,
	output result_t          result
);

	localparam int unsigned IDX_W = (ROM_BITS > 1) ? $clog2(ROM_BITS) : 1;
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(ROM_BITS);
	localparam logic [POS_W-1:0] IDLE_POS = POS_W'(ROM_BITS + 1);
	localparam logic [POS_W-1:0] FIRST_POS = POS_W'(1);

	logic [CMD_W-1:0]    search_command_q;
	logic [ROM_BITS-1:0] rom_store_q, rom_store_nxt;
	logic [POS_W-1:0]    last_disc_q, last_disc_nxt;
	logic [POS_W-1:0]    disc_mark_q, disc_mark_nxt;
	logic [POS_W-1:0]    bit_pos_q, bit_pos_nxt;
	logic                active_q, active_nxt;
	logic [COUNT_W-1:0]  found_q, found_nxt;

	logic [POS_W-1:0] pos_m1;
	logic [IDX_W-1:0] bit_idx;
	logic             dir;
	logic             pass_open;

	assign pos_m1    = bit_pos_q - FIRST_POS;
	assign bit_idx   = pos_m1[IDX_W-1:0];
	assign pass_open = (bit_pos_q >= FIRST_POS) && (bit_pos_q <= LAST_POS);

	// Hold the search command register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_command_q <= CMD_RESET;
		end else if (cfg_we) begin
			search_command_q <= cfg_wdata;
		end
	end

	// Pick the branch for the current bit
	always_comb begin
		if (item_s1.true_bit != item_s1.complement_bit) begin
			dir = item_s1.true_bit;
		end else if (bit_pos_q == last_disc_q) begin
			dir = 1'b1;
		end else if (bit_pos_q > last_disc_q) begin
			dir = 1'b0;
		end else begin
			dir = rom_store_q[bit_idx];
		end
	end

	// Next state and result for the held transaction
	always_comb begin
		rom_store_nxt = rom_store_q;
		last_disc_nxt = last_disc_q;
		disc_mark_nxt = disc_mark_q;
		bit_pos_nxt   = bit_pos_q;
		active_nxt    = active_q;
		found_nxt     = found_q;
		result        = '0;
		case (op_t'(item_s1.operation))
			OP_START: begin
				rom_store_nxt = '0;
				last_disc_nxt = '0;
				disc_mark_nxt = '0;
				found_nxt     = '0;
				bit_pos_nxt   = IDLE_POS;
				active_nxt    = 1'b1;
			end
			OP_PASS: begin
				if (active_q) begin
					if (!item_s1.presence) begin
						result.status = STATUS_NO_PRESENCE;
						active_nxt    = 1'b0;
						bit_pos_nxt   = IDLE_POS;
					end else begin
						result.command_byte = search_command_q;
						bit_pos_nxt         = FIRST_POS;
						disc_mark_nxt       = '0;
					end
				end
			end
			OP_BIT: begin
				if (active_q && pass_open) begin
					if (item_s1.true_bit && item_s1.complement_bit) begin
						// Nobody drove the slot: abort the search
						result.status = STATUS_NO_ANSWER;
						disc_mark_nxt = '0;
						active_nxt    = 1'b0;
						bit_pos_nxt   = IDLE_POS;
					end else begin
						// Mark a zero taken at an open branch
						if ((item_s1.true_bit == item_s1.complement_bit) && !dir &&
						    (bit_pos_q != last_disc_q)) begin
							disc_mark_nxt = bit_pos_q;
						end
						rom_store_nxt[bit_idx] = dir;
						result.write_bit       = dir;
						if (bit_pos_q == LAST_POS) begin
							// Close the pass
							last_disc_nxt    = disc_mark_nxt;
							if (found_q != COUNT_MAX) begin
								found_nxt = found_q + COUNT_W'(1);
							end
							result.found_rom = ROM_CODE_W'(rom_store_nxt);
							result.rom_valid = 1'b1;
							bit_pos_nxt      = IDLE_POS;
							if (disc_mark_nxt == '0) begin
								active_nxt = 1'b0;
							end
						end else begin
							bit_pos_nxt = bit_pos_q + FIRST_POS;
						end
					end
				end
			end
			default: begin
				// Unused code: no state change
			end
		endcase
		result.search_done  = !active_nxt;
		result.device_count = found_nxt;
	end

	// Advance state when the transaction moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_store_q <= '0;
			last_disc_q <= '0;
			disc_mark_q <= '0;
			bit_pos_q   <= FIRST_POS;
			active_q    <= 1'b0;
			found_q     <= '0;
		end else if (take) begin
			rom_store_q <= rom_store_nxt;
			last_disc_q <= last_disc_nxt;
			disc_mark_q <= disc_mark_nxt;
			bit_pos_q   <= bit_pos_nxt;
			active_q    <= active_nxt;
			found_q     <= found_nxt;
		end
	end

endmodule

// File: sv/owrs_out_stage.sv
// Result register: holds one result transaction until the consumer takes it.
module owrs_out_stage
	import owrs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    valid_s1,
	input  result_t result_in,
	output logic    take,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result_q
);

	// Load when empty or when the held result leaves this cycle
	assign take = valid_s1 && (!result_valid || result_ready);

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (take) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	// Capture payload
	always_ff @(posedge clk) begin
		if (take) begin
			result_q <= result_in;
		end
	end

endmodule

// File: sv/one_wire_rom_search_core.sv
// Top level of the 1-Wire ROM search decision core.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+--------------------------------------------
//  item     | item_valid / item_ready     | operation, presence, true_bit, complement_bit
//  result   | result_valid / result_ready | write_bit, command_byte, found_rom, rom_valid,
//           |                             | search_done, status, device_count
//  config   | cfg_we (no wait)            | cfg_wdata -> search command byte
//
// One transaction per cycle sustained while results are taken. An accepted item is decided
// as it sits in the input register, then offered as a result from the result register.
// Reset (arst_n low) clears the search state at once and loads command 0xF0.
// A stalled result holds the decision stage; the input register takes one more item only if empty.
module one_wire_rom_search_core
	import owrs_pkg::*;
#(
	parameter int unsigned ROM_BITS = ROM_BITS_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CMD_W-1:0]      cfg_wdata,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  logic [OP_W-1:0]       operation,
	input  logic                  presence,
	input  logic                  true_bit,
	input  logic                  complement_bit,
	output logic                  result_valid,
	input  logic                  result_ready,
	output logic                  write_bit,
	output logic [CMD_W-1:0]      command_byte,
	output logic [ROM_CODE_W-1:0] found_rom,
	output logic                  rom_valid,
	output logic                  search_done,
	output logic [STATUS_W-1:0]   status,
	output logic [COUNT_W-1:0]    device_count
);

	item_t   item_in;
	item_t   item_s1;
	logic    valid_s1;
	logic    take;
	result_t result_d;
	result_t result_q;

	assign item_in.operation      = operation;
	assign item_in.presence       = presence;
	assign item_in.true_bit       = true_bit;
	assign item_in.complement_bit = complement_bit;

	owrs_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item_in    (item_in),
		.take       (take),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	owrs_decide #(
		.ROM_BITS (ROM_BITS)
	) u_decide (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.take      (take),
		.item_s1   (item_s1),
		.result    (result_d)
	);

	owrs_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.result_in    (result_d),
		.take         (take),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_q     (result_q)
	);

	// Drive result ports
	assign write_bit    = result_q.write_bit;
	assign command_byte = result_q.command_byte;
	assign found_rom    = result_q.found_rom;
	assign rom_valid    = result_q.rom_valid;
	assign search_done  = result_q.search_done;
	assign status       = result_q.status;
	assign device_count = result_q.device_count;

endmodule

// File: sv/owrs_checker.sv
// Port-level checks for the ROM search core, bound to the top level.
module owrs_checker
	import owrs_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  result_valid,
	input logic                  result_ready,
	input logic                  write_bit,
	input logic [CMD_W-1:0]      command_byte,
	input logic                  rom_valid,
	input logic                  search_done,
	input logic [STATUS_W-1:0]   status,
	input logic [COUNT_W-1:0]    device_count
);

	// A stalled result transaction holds its valid, status, rom_valid and device_count
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(status) &&
		$stable(rom_valid) && $stable(device_count))
		else $error("stalled result changed");

	// A found ROM comes only with ok status and no command
	a_rom_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && rom_valid |-> status == STATUS_OK && command_byte == '0)
		else $error("found ROM with error or command");

	// Any error ends the search, with no found ROM and no write bit
	a_error_done: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status != STATUS_OK |-> search_done && !rom_valid && !write_bit)
		else $error("error without search end");

	// A found device counts at least one
	a_rom_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && rom_valid |-> device_count != '0)
		else $error("found ROM with zero count");

endmodule

bind one_wire_rom_search_core owrs_checker u_owrs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.write_bit    (write_bit),
	.command_byte (command_byte),
	.rom_valid    (rom_valid),
	.search_done  (search_done),
	.status       (status),
	.device_count (device_count)
);
